[hdl/line_segment_window_clipper_defines.svh]
// Assertion macros for the port-level checker of the window clipper.
`ifndef LINE_SEGMENT_WINDOW_CLIPPER_DEFINES_SVH
`define LINE_SEGMENT_WINDOW_CLIPPER_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define LSW_ASSERT_IMPLY(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("clipper assertion failed");

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define LSW_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("clipper assertion failed");

`endif

[hdl/lsw_pkg.sv]
// Package of the line segment window clipper: defaults, register codes, types.
`timescale 1ns / 1ps
`default_nettype none
package lsw_pkg;

    localparam int DEF_COORD_BITS    = 16;
    localparam int DEF_FRACTION_BITS = 16;
    localparam int NUM_PAIRS         = 4;
    localparam int CFG_INDEX_BITS    = 2;

    localparam int WINDOW_LEFT_RESET   = 100;
    localparam int WINDOW_TOP_RESET    = 100;
    localparam int WINDOW_RIGHT_RESET  = 300;
    localparam int WINDOW_BOTTOM_RESET = 200;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LEFT   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_TOP    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_RIGHT  = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_BOTTOM = 2'd3;

    // Per-segment classification of the four boundary pairs.
    typedef struct packed {
        logic                 kill;   // segment is rejected outright
        logic [NUM_PAIRS-1:0] enter;  // pair tightens the entry parameter
        logic [NUM_PAIRS-1:0] leave;  // pair tightens the exit parameter
        logic [NUM_PAIRS-1:0] sat;    // ratio is at least 1.0
    } pair_ctl_t;

endpackage
`default_nettype wire

[hdl/lsw_setup.sv]
// First stage: differences, boundary pairs, magnitudes and classification.
`timescale 1ns / 1ps
`default_nettype none
module lsw_setup #(
    parameter int COORD_BITS = lsw_pkg::DEF_COORD_BITS
) (
    input  wire                           clk,
    input  wire                           en,
    input  wire  signed [COORD_BITS-1:0]  x1,
    input  wire  signed [COORD_BITS-1:0]  y1,
    input  wire  signed [COORD_BITS-1:0]  x2,
    input  wire  signed [COORD_BITS-1:0]  y2,
    input  wire  signed [COORD_BITS-1:0]  win_left,
    input  wire  signed [COORD_BITS-1:0]  win_top,
    input  wire  signed [COORD_BITS-1:0]  win_right,
    input  wire  signed [COORD_BITS-1:0]  win_bottom,
    output logic        [COORD_BITS-1:0]  abs_p [lsw_pkg::NUM_PAIRS],
    output logic        [COORD_BITS-1:0]  abs_q [lsw_pkg::NUM_PAIRS],
    output lsw_pkg::pair_ctl_t            ctl,
    output logic signed [COORD_BITS-1:0]  x1_out,
    output logic signed [COORD_BITS-1:0]  y1_out,
    output logic signed [COORD_BITS:0]    dx_out,
    output logic signed [COORD_BITS:0]    dy_out
);

    logic signed [COORD_BITS:0] dx, dy;
    logic signed [COORD_BITS:0] p [lsw_pkg::NUM_PAIRS];
    logic signed [COORD_BITS:0] q [lsw_pkg::NUM_PAIRS];
    logic        [COORD_BITS:0] mp [lsw_pkg::NUM_PAIRS];
    logic        [COORD_BITS:0] mq [lsw_pkg::NUM_PAIRS];
    lsw_pkg::pair_ctl_t         ctl_next;

    assign dx = $signed({x2[COORD_BITS-1], x2}) - $signed({x1[COORD_BITS-1], x1});
    assign dy = $signed({y2[COORD_BITS-1], y2}) - $signed({y1[COORD_BITS-1], y1});

    always_comb
    begin
        p[0] = -dx;
        q[0] = $signed({x1[COORD_BITS-1], x1}) - $signed({win_left[COORD_BITS-1], win_left});
        p[1] = dx;
        q[1] = $signed({win_right[COORD_BITS-1], win_right}) - $signed({x1[COORD_BITS-1], x1});
        p[2] = -dy;
        q[2] = $signed({y1[COORD_BITS-1], y1}) - $signed({win_top[COORD_BITS-1], win_top});
        p[3] = dy;
        q[3] = $signed({win_bottom[COORD_BITS-1], win_bottom})
               - $signed({y1[COORD_BITS-1], y1});
        ctl_next = '0;
        for (int i = 0; i < lsw_pkg::NUM_PAIRS; i++)
        begin
            mp[i] = p[i][COORD_BITS] ? $unsigned(-p[i]) : $unsigned(p[i]);
            mq[i] = q[i][COORD_BITS] ? $unsigned(-q[i]) : $unsigned(q[i]);
            // A zero pair with negative q, or an exit pair with negative q, rejects.
            if (q[i][COORD_BITS] && !p[i][COORD_BITS])
            begin
                ctl_next.kill = 1'b1;
            end
            ctl_next.enter[i] = p[i][COORD_BITS] && q[i][COORD_BITS];
            ctl_next.leave[i] = !p[i][COORD_BITS] && (p[i] != '0) && !q[i][COORD_BITS];
            ctl_next.sat[i]   = mq[i] >= mp[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < lsw_pkg::NUM_PAIRS; i++)
            begin
                abs_p[i] <= mp[i][COORD_BITS-1:0];
                abs_q[i] <= mq[i][COORD_BITS-1:0];
            end
            ctl    <= ctl_next;
            x1_out <= x1;
            y1_out <= y1;
            dx_out <= dx;
            dy_out <= dy;
        end
    end

endmodule
`default_nettype wire

[hdl/lsw_div.sv]
// Pipelined restoring divider lane: one quotient bit of num * 2^F / den per stage.
`timescale 1ns / 1ps
`default_nettype none
module lsw_div #(
    parameter int COORD_BITS    = lsw_pkg::DEF_COORD_BITS,
    parameter int FRACTION_BITS = lsw_pkg::DEF_FRACTION_BITS
) (
    input  wire                        clk,
    input  wire  [FRACTION_BITS-1:0]   en,
    input  wire  [COORD_BITS-1:0]      num,
    input  wire  [COORD_BITS-1:0]      den,
    output logic [FRACTION_BITS-1:0]   quo
);

    logic [COORD_BITS-1:0]    rem_reg [FRACTION_BITS];
    logic [COORD_BITS-1:0]    den_reg [FRACTION_BITS];
    logic [FRACTION_BITS-1:0] quo_reg [FRACTION_BITS];

    for (genvar k = 0; k < FRACTION_BITS; k++)
    begin : g_stage
        logic [COORD_BITS-1:0]    r_in;
        logic [COORD_BITS-1:0]    d_in;
        logic [FRACTION_BITS-1:0] q_in;
        logic [COORD_BITS:0]      shifted;
        logic [COORD_BITS:0]      diff;
        logic                     ge;
        logic [COORD_BITS-1:0]    rem_next;

        if (k == 0)
        begin : g_first
            assign r_in = num;
            assign d_in = den;
            assign q_in = '0;
        end
        else
        begin : g_rest
            assign r_in = rem_reg[k-1];
            assign d_in = den_reg[k-1];
            assign q_in = quo_reg[k-1];
        end

        assign shifted  = {r_in, 1'b0};
        assign diff     = shifted - {1'b0, d_in};
        assign ge       = shifted >= {1'b0, d_in};
        assign rem_next = ge ? diff[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= d_in;
                quo_reg[k] <= {q_in[FRACTION_BITS-2:0], ge};
            end
        end
    end

    assign quo = quo_reg[FRACTION_BITS-1];

endmodule
`default_nettype wire

[hdl/lsw_interp.sv]
// Back end: entry/exit selection, endpoint multiplies, rounding toward zero.
`timescale 1ns / 1ps
`default_nettype none
module lsw_interp #(
    parameter int COORD_BITS    = lsw_pkg::DEF_COORD_BITS,
    parameter int FRACTION_BITS = lsw_pkg::DEF_FRACTION_BITS
) (
    input  wire                           clk,
    input  wire  [2:0]                    en,
    input  wire  lsw_pkg::pair_ctl_t      ctl,
    input  wire  [FRACTION_BITS-1:0]      quo [lsw_pkg::NUM_PAIRS],
    input  wire  signed [COORD_BITS-1:0]  x1,
    input  wire  signed [COORD_BITS-1:0]  y1,
    input  wire  signed [COORD_BITS:0]    dx,
    input  wire  signed [COORD_BITS:0]    dy,
    output logic                          visible,
    output logic [COORD_BITS-1:0]         start_x,
    output logic [COORD_BITS-1:0]         start_y,
    output logic [COORD_BITS-1:0]         end_x,
    output logic [COORD_BITS-1:0]         end_y
);

    localparam int F  = FRACTION_BITS;
    localparam int PW = COORD_BITS + F + 3;
    localparam int SW = COORD_BITS + F + 4;
    localparam logic [F:0] T_ONE = {1'b1, {F{1'b0}}};

    // Selection stage.
    logic [F:0] t1_next, t2_next, r;
    logic       vis_next;
    logic [F:0] t1_reg, t2_reg;
    logic       vis_sel_reg;
    logic signed [COORD_BITS-1:0] x1_sel_reg, y1_sel_reg;
    logic signed [COORD_BITS:0]   dx_sel_reg, dy_sel_reg;

    always_comb
    begin
        t1_next = '0;
        t2_next = T_ONE;
        r       = '0;
        for (int i = 0; i < lsw_pkg::NUM_PAIRS; i++)
        begin
            r = ctl.sat[i] ? T_ONE : {1'b0, quo[i]};
            if (ctl.enter[i] && (r > t1_next))
            begin
                t1_next = r;
            end
            if (ctl.leave[i] && (r < t2_next))
            begin
                t2_next = r;
            end
        end
        vis_next = !ctl.kill && (t1_next < t2_next);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            t1_reg      <= t1_next;
            t2_reg      <= t2_next;
            vis_sel_reg <= vis_next;
            x1_sel_reg  <= x1;
            y1_sel_reg  <= y1;
            dx_sel_reg  <= dx;
            dy_sel_reg  <= dy;
        end
    end

    // Multiply stage: t times the delta for each clipped coordinate.
    logic signed [F+1:0]  t1_s, t2_s;
    logic signed [PW-1:0] psx_reg, psy_reg, pex_reg, pey_reg;
    logic signed [COORD_BITS-1:0] x1_mul_reg, y1_mul_reg;
    logic vis_mul_reg;

    assign t1_s = $signed({1'b0, t1_reg});
    assign t2_s = $signed({1'b0, t2_reg});

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            psx_reg     <= t1_s * dx_sel_reg;
            psy_reg     <= t1_s * dy_sel_reg;
            pex_reg     <= t2_s * dx_sel_reg;
            pey_reg     <= t2_s * dy_sel_reg;
            x1_mul_reg  <= x1_sel_reg;
            y1_mul_reg  <= y1_sel_reg;
            vis_mul_reg <= vis_sel_reg;
        end
    end

    // Sum and divide by 2^F with truncation toward zero.
    function automatic logic [COORD_BITS-1:0] lerp_trunc(
        input logic signed [COORD_BITS-1:0] c,
        input logic signed [PW-1:0]         prod
    );
        logic signed [SW-1:0] v;
        logic signed [SW-1:0] sh;
        v  = ($signed({{(SW-COORD_BITS){c[COORD_BITS-1]}}, c}) <<< F)
             + $signed({{(SW-PW){prod[PW-1]}}, prod});
        sh = v >>> F;
        if (v[SW-1] && (v[F-1:0] != '0))
        begin
            sh = sh + SW'(1);
        end
        return sh[COORD_BITS-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            visible <= vis_mul_reg;
            start_x <= vis_mul_reg ? lerp_trunc(x1_mul_reg, psx_reg) : '0;
            start_y <= vis_mul_reg ? lerp_trunc(y1_mul_reg, psy_reg) : '0;
            end_x   <= vis_mul_reg ? lerp_trunc(x1_mul_reg, pex_reg) : '0;
            end_y   <= vis_mul_reg ? lerp_trunc(y1_mul_reg, pey_reg) : '0;
        end
    end

endmodule
`default_nettype wire

[hdl/line_segment_window_clipper.sv]
// Top level of the line segment window clipper (Liang-Barsky, fixed point).
//
// Channel   Direction  tdata (low bit up)                     tuser
// s_axis    in         start_x, start_y, end_x, end_y         -
// m_axis    out        clipped_start_x/_y, clipped_end_x/_y   visible
// cfg       in         write: cfg_we, cfg_index, cfg_data     -
//
// Every cycle a segment transaction can be accepted unless the output stalls; each
// one yields exactly one result. The pipeline has a setup stage, one divider stage
// per fraction bit (four lanes in parallel), a selection stage, a multiply stage and the output stage.
// Each stage advances when it is empty or the stage after it advances, so a stall at
// the output only backs up as far as the pipeline is full and loses nothing.
// Reset clears the valid bits and loads the window registers with 100, 100, 300, 200.
`timescale 1ns / 1ps
`default_nettype none
module line_segment_window_clipper #(
    parameter int COORD_BITS    = lsw_pkg::DEF_COORD_BITS,
    parameter int FRACTION_BITS = lsw_pkg::DEF_FRACTION_BITS,
    localparam int IN_W  = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((4 * COORD_BITS + 7) / 8) * 8
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire  [IN_W-1:0]                      s_tdata,   // start_x, start_y, end_x, end_y
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [OUT_W-1:0]                     m_tdata,   // clipped start_x/y, end_x/y
    output logic                                 m_tuser,   // visible
    input  wire                                  cfg_we,
    input  wire  [lsw_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire  [COORD_BITS-1:0]                cfg_data
);

    localparam int F = FRACTION_BITS;
    localparam int N = F + 4;
    localparam int C = COORD_BITS;

    // Window registers.
    logic signed [C-1:0] win_left_reg, win_top_reg, win_right_reg, win_bottom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg   <= C'(lsw_pkg::WINDOW_LEFT_RESET);
            win_top_reg    <= C'(lsw_pkg::WINDOW_TOP_RESET);
            win_right_reg  <= C'(lsw_pkg::WINDOW_RIGHT_RESET);
            win_bottom_reg <= C'(lsw_pkg::WINDOW_BOTTOM_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lsw_pkg::REG_WINDOW_LEFT:   win_left_reg   <= cfg_data;
                lsw_pkg::REG_WINDOW_TOP:    win_top_reg    <= cfg_data;
                lsw_pkg::REG_WINDOW_RIGHT:  win_right_reg  <= cfg_data;
                lsw_pkg::REG_WINDOW_BOTTOM: win_bottom_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage valid bits and advance enables. The enable of a stage is true when the
    // stage is empty or the next one moves, so bubbles are squeezed out under stall.
    logic [N-1:0] valid_reg;
    logic [N-1:0] en;

    always_comb
    begin
        en[N-1] = !valid_reg[N-1] || m_tready;
        for (int i = N - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < N; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[N-1];

    // Setup stage.
    logic [C-1:0]        abs_p [lsw_pkg::NUM_PAIRS];
    logic [C-1:0]        abs_q [lsw_pkg::NUM_PAIRS];
    lsw_pkg::pair_ctl_t  ctl0;
    logic signed [C-1:0] x1_0, y1_0;
    logic signed [C:0]   dx_0, dy_0;

    lsw_setup #(
        .COORD_BITS (C)
    ) u_setup (
        .clk        (clk),
        .en         (en[0]),
        .x1         (s_tdata[C-1:0]),
        .y1         (s_tdata[2*C-1:C]),
        .x2         (s_tdata[3*C-1:2*C]),
        .y2         (s_tdata[4*C-1:3*C]),
        .win_left   (win_left_reg),
        .win_top    (win_top_reg),
        .win_right  (win_right_reg),
        .win_bottom (win_bottom_reg),
        .abs_p      (abs_p),
        .abs_q      (abs_q),
        .ctl        (ctl0),
        .x1_out     (x1_0),
        .y1_out     (y1_0),
        .dx_out     (dx_0),
        .dy_out     (dy_0)
    );

    // Four divider lanes, one per boundary pair.
    logic [F-1:0] quo [lsw_pkg::NUM_PAIRS];

    for (genvar i = 0; i < lsw_pkg::NUM_PAIRS; i++)
    begin : g_lane
        lsw_div #(
            .COORD_BITS    (C),
            .FRACTION_BITS (F)
        ) u_div (
            .clk (clk),
            .en  (en[F:1]),
            .num (abs_q[i]),
            .den (abs_p[i]),
            .quo (quo[i])
        );
    end

    // Side data travels beside the divider lanes.
    lsw_pkg::pair_ctl_t  ctl_reg [F];
    logic signed [C-1:0] x1_reg [F];
    logic signed [C-1:0] y1_reg [F];
    logic signed [C:0]   dx_reg [F];
    logic signed [C:0]   dy_reg [F];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ctl_reg[0] <= ctl0;
            x1_reg[0]  <= x1_0;
            y1_reg[0]  <= y1_0;
            dx_reg[0]  <= dx_0;
            dy_reg[0]  <= dy_0;
        end
        for (int k = 1; k < F; k++)
        begin
            if (en[k+1])
            begin
                ctl_reg[k] <= ctl_reg[k-1];
                x1_reg[k]  <= x1_reg[k-1];
                y1_reg[k]  <= y1_reg[k-1];
                dx_reg[k]  <= dx_reg[k-1];
                dy_reg[k]  <= dy_reg[k-1];
            end
        end
    end

    // Selection, multiply and output stages.
    logic [C-1:0] o_sx, o_sy, o_ex, o_ey;

    lsw_interp #(
        .COORD_BITS    (C),
        .FRACTION_BITS (F)
    ) u_interp (
        .clk     (clk),
        .en      (en[N-1:F+1]),
        .ctl     (ctl_reg[F-1]),
        .quo     (quo),
        .x1      (x1_reg[F-1]),
        .y1      (y1_reg[F-1]),
        .dx      (dx_reg[F-1]),
        .dy      (dy_reg[F-1]),
        .visible (m_tuser),
        .start_x (o_sx),
        .start_y (o_sy),
        .end_x   (o_ex),
        .end_y   (o_ey)
    );

    assign m_tdata = OUT_W'({o_ey, o_ex, o_sy, o_sx});

endmodule
`default_nettype wire

[hdl/lsw_checker.sv]
// Port-level checker for the window clipper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "line_segment_window_clipper_defines.svh"
module lsw_port_checker #(
    parameter int COORD_BITS = lsw_pkg::DEF_COORD_BITS,
    localparam int OUT_W = ((4 * COORD_BITS + 7) / 8) * 8
) (
    input wire             clk,
    input wire             rst_n,
    input wire             s_tready,
    input wire             m_tvalid,
    input wire             m_tready,
    input wire [OUT_W-1:0] m_tdata,
    input wire             m_tuser
);

    // A hidden segment always reports zero coordinates.
    `LSW_ASSERT_IMPLY(a_hidden_zero, m_tvalid && !m_tuser, m_tdata == '0)

    // With the output free or draining, the input side must be open.
    `LSW_ASSERT_IMPLY(a_ready_when_free, !m_tvalid || m_tready, s_tready)

    // A result that is not taken stays in place.
    `LSW_ASSERT_NEXT(a_hold, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind line_segment_window_clipper lsw_port_checker #(
    .COORD_BITS (COORD_BITS)
) u_lsw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

[tb/sv/lsw_checker.sv]
// Checker for the window clipper: it predicts each clipped segment and compares the results.
`timescale 1ns / 1ps
module lsw_checker (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [63:0] s_tdata,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [63:0] m_tdata,
    input  wire         m_tuser,
    input  wire         cfg_we,
    input  wire  [lsw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire  [15:0] cfg_data,
    output int          errors,
    output int          pending,
    output int          visible_count
);
    import lsw_pkg::*;

    localparam int FRAC = 16;
    localparam longint T_ONE = longint'(1) << FRAC;
    localparam longint T_SAT = (longint'(1) << (FRAC + 1)) - 1;

    typedef struct {
        logic        visible;
        logic [15:0] start_x;
        logic [15:0] start_y;
        logic [15:0] end_x;
        logic [15:0] end_y;
    } clip_result_t;

    clip_result_t clipped_q[$];
    longint left_edge, top_edge, right_edge, bottom_edge;

    function automatic longint crossing(longint q, longint p);
        longint aq;
        longint ap;
        longint r;
        aq = (q < 0) ? -q : q;
        ap = (p < 0) ? -p : p;
        r = (aq << FRAC) / ap;
        return (r > T_SAT) ? T_SAT : r;
    endfunction

    function automatic logic [15:0] along(longint c, longint d, longint t);
        longint v;
        v = c * T_ONE + t * d;
        return 16'(v / T_ONE);
    endfunction

    function automatic clip_result_t clip_segment(logic [63:0] seg);
        longint x1;
        longint y1;
        longint dx;
        longint dy;
        longint p[4];
        longint q[4];
        longint t_in;
        longint t_out;
        longint r;
        logic rejected;
        clip_result_t res;
        x1 = longint'($signed(seg[15:0]));
        y1 = longint'($signed(seg[31:16]));
        dx = longint'($signed(seg[47:32])) - x1;
        dy = longint'($signed(seg[63:48])) - y1;
        p[0] = -dx; q[0] = x1 - left_edge;
        p[1] = dx;  q[1] = right_edge - x1;
        p[2] = -dy; q[2] = y1 - top_edge;
        p[3] = dy;  q[3] = bottom_edge - y1;
        t_in = 0;
        t_out = T_ONE;
        rejected = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (p[i] == 0)
            begin
                if (q[i] < 0)
                    rejected = 1'b1;
            end
            else if (p[i] < 0)
            begin
                if (q[i] < 0)
                begin
                    r = crossing(q[i], p[i]);
                    if (r > t_in)
                        t_in = r;
                end
            end
            else
            begin
                r = (q[i] < 0) ? 0 : crossing(q[i], p[i]);
                if (r < t_out)
                    t_out = r;
            end
        end
        res = '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0};
        if (!rejected && t_in < t_out)
        begin
            res.visible = 1'b1;
            res.start_x = along(x1, dx, t_in);
            res.start_y = along(y1, dy, t_in);
            res.end_x   = along(x1, dx, t_out);
            res.end_y   = along(y1, dy, t_out);
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        clip_result_t want;
        if (!rst_n)
        begin
            left_edge   = WINDOW_LEFT_RESET;
            top_edge    = WINDOW_TOP_RESET;
            right_edge  = WINDOW_RIGHT_RESET;
            bottom_edge = WINDOW_BOTTOM_RESET;
            errors = 0;
            visible_count = 0;
            clipped_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (clipped_q.size() == 0)
                begin
                    $error("result transaction with no segment outstanding");
                    errors++;
                end
                else
                begin
                    want = clipped_q.pop_front();
                    if (m_tuser !== want.visible)
                    begin
                        $error("visible: expected %0d, got %0d", want.visible, m_tuser);
                        errors++;
                    end
                    if (m_tdata[15:0] !== want.start_x)
                    begin
                        $error("clipped_start_x: expected %0d, got %0d",
                               $signed(want.start_x), $signed(m_tdata[15:0]));
                        errors++;
                    end
                    if (m_tdata[31:16] !== want.start_y)
                    begin
                        $error("clipped_start_y: expected %0d, got %0d",
                               $signed(want.start_y), $signed(m_tdata[31:16]));
                        errors++;
                    end
                    if (m_tdata[47:32] !== want.end_x)
                    begin
                        $error("clipped_end_x: expected %0d, got %0d",
                               $signed(want.end_x), $signed(m_tdata[47:32]));
                        errors++;
                    end
                    if (m_tdata[63:48] !== want.end_y)
                    begin
                        $error("clipped_end_y: expected %0d, got %0d",
                               $signed(want.end_y), $signed(m_tdata[63:48]));
                        errors++;
                    end
                    if (want.visible)
                        visible_count++;
                end
            end
            if (s_tvalid && s_tready)
                clipped_q.push_back(clip_segment(s_tdata));
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WINDOW_LEFT:   left_edge   = longint'($signed(cfg_data));
                    REG_WINDOW_TOP:    top_edge    = longint'($signed(cfg_data));
                    REG_WINDOW_RIGHT:  right_edge  = longint'($signed(cfg_data));
                    REG_WINDOW_BOTTOM: bottom_edge = longint'($signed(cfg_data));
                    default: ;
                endcase
            end
        end
        pending = clipped_q.size();
    end
endmodule

[tb/sv/tb.sv]
// Testbench top of the window clipper: stimulus, flow control and the verdict.
`timescale 1ns / 1ps
module tb;
    import lsw_pkg::*;

    // The pipeline is FRACTION_BITS + 4 = 20 stages deep; the guard adds some margin.
    localparam int LATENCY_GUARD = 30;
    localparam int CYCLE_LIMIT   = 600000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    wire         s_tready;
    logic [63:0] s_tdata;    // start_x, start_y, end_x, end_y
    wire         m_tvalid;
    logic        m_tready;
    wire  [63:0] m_tdata;    // clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y
    wire         m_tuser;    // visible
    logic        cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [15:0] cfg_data;

    int errors;
    int pending;
    int visible_count;
    int segments_sent;
    int windows_used;
    int cycles;
    int hold_left;      // receiver hold-off request, counted down by the receiver
    bit sender_idles;   // when clear the sender offers back to back
    bit sink_idles;     // when clear the receiver is always ready
    int win_lo_x, win_lo_y, win_hi_x, win_hi_y;

    line_segment_window_clipper u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    lsw_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending),
        .visible_count(visible_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 65)
            return 0;
        else if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver. A pending hold-off request keeps tready low for its whole length,
    // otherwise tready follows random stall stretches.
    initial
    begin
        int stall;
        stall = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (sink_idles && $urandom_range(3) == 0)
                    stall = pick_gap();
            end
        end
    end

    // One segment transaction. It is entered just after a rising edge and returns
    // just after the edge at which the segment was accepted (or after the gap).
    task automatic send_segment(input logic [15:0] sx, input logic [15:0] sy,
                                input logic [15:0] ex, input logic [15:0] ey);
        int gap;
        s_tdata  <= {ey, ex, sy, sx};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        segments_sent++;
        gap = sender_idles ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every outstanding result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Window registers are only written once the pipeline is empty.
    task automatic program_window(input int lo_x, input int lo_y, input int hi_x, input int hi_y);
        drain();
        repeat (LATENCY_GUARD) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_WINDOW_LEFT;
        cfg_data  <= 16'(lo_x);
        @(posedge clk);
        cfg_index <= REG_WINDOW_TOP;
        cfg_data  <= 16'(lo_y);
        @(posedge clk);
        cfg_index <= REG_WINDOW_RIGHT;
        cfg_data  <= 16'(hi_x);
        @(posedge clk);
        cfg_index <= REG_WINDOW_BOTTOM;
        cfg_data  <= 16'(hi_y);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        win_lo_x = lo_x;
        win_lo_y = lo_y;
        win_hi_x = hi_x;
        win_hi_y = hi_y;
        windows_used++;
    endtask

    // A coordinate somewhere around the span [lo, hi]; wraps at the field width.
    function automatic logic [15:0] near(input int lo, input int hi);
        int a;
        int b;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        return 16'($urandom_range(b - a + 80) + a - 40);
    endfunction

    // Random segment: mostly near the window so that clipping really happens,
    // with some fully random, degenerate and axis-parallel segments mixed in.
    task automatic send_random_segment();
        logic [15:0] sx, sy, ex, ey;
        int kind;
        kind = $urandom_range(99);
        sx = near(win_lo_x, win_hi_x);
        sy = near(win_lo_y, win_hi_y);
        ex = near(win_lo_x, win_hi_x);
        ey = near(win_lo_y, win_hi_y);
        if (kind < 20)
        begin
            sx = 16'($urandom);
            sy = 16'($urandom);
            ex = 16'($urandom);
            ey = 16'($urandom);
        end
        else if (kind < 28)
        begin
            ex = sx;
            ey = sy;
        end
        else if (kind < 36)
            ey = sy;
        else if (kind < 44)
            ex = sx;
        else if (kind < 52)
        begin
            // Long segment reaching far outside on one end.
            ex = 16'($urandom);
        end
        send_segment(sx, sy, ex, ey);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_random_segment();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_we       = 1'b0;
        cfg_index    = REG_WINDOW_LEFT;
        cfg_data     = '0;
        hold_left    = 0;
        sender_idles = 1'b1;
        sink_idles   = 1'b1;
        segments_sent = 0;
        windows_used  = 1;
        win_lo_x = WINDOW_LEFT_RESET;
        win_lo_y = WINDOW_TOP_RESET;
        win_hi_x = WINDOW_RIGHT_RESET;
        win_hi_y = WINDOW_BOTTOM_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed segments against the reset window (100..300, 100..200).
        send_segment(16'sd150, 16'sd150, 16'sd250, 16'sd180);      // fully inside
        send_segment(16'sd0, 16'sd150, 16'sd400, 16'sd150);        // horizontal, cut both ends
        send_segment(16'sd400, 16'sd150, 16'sd0, 16'sd150);        // same, reversed
        send_segment(16'sd200, 16'sd0, 16'sd200, 16'sd400);        // vertical, cut both ends
        send_segment(16'sd0, 16'sd50, 16'sd400, 16'sd50);          // horizontal above window
        send_segment(16'sd50, 16'sd0, 16'sd50, 16'sd400);          // vertical left of window
        send_segment(16'sd150, 16'sd150, 16'sd150, 16'sd150);      // single point inside
        send_segment(16'sd100, 16'sd200, 16'sd100, 16'sd200);      // single point on a corner
        send_segment(16'sd300, 16'sd150, 16'sd300, 16'sd150);      // single point on right edge
        send_segment(16'sd301, 16'sd150, 16'sd301, 16'sd150);      // single point just outside
        send_segment(16'sd0, 16'sd0, 16'sd50, 16'sd50);            // outside, misses
        send_segment(16'sd0, 16'sd0, 16'sd400, 16'sd300);          // diagonal through window
        send_segment(16'sd350, 16'sd250, 16'sd250, 16'sd150);      // enters from the far corner
        send_segment(16'sd250, 16'sd150, 16'sd1000, 16'sd150);     // starts inside, leaves
        send_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);      // full-range diagonal
        send_segment(16'h7fff, 16'h7fff, 16'h8000, 16'h8000);      // same, reversed
        send_segment(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);      // anti-diagonal misses
        send_segment(16'h8000, 16'sd150, 16'h7fff, 16'sd150);      // full-range horizontal
        send_segment(16'sd200, 16'h8000, 16'sd200, 16'h7fff);      // full-range vertical
        send_segment(16'sd0, 16'sd140, 16'sd110, 16'sd90);         // passes just outside the top-left corner, misses
        send_segment(16'sd299, 16'sd199, 16'sd301, 16'sd201);      // grazes a corner
        run_random(215);

        // The receiver holds off long enough for the pipeline to fill and stall the input.
        hold_left = 300;
        sender_idles = 1'b0;
        run_random(80);
        sender_idles = 1'b1;

        // Widest window: everything inside, only the full-range edges matter.
        program_window(-32768, -32768, 32767, 32767);
        send_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        send_segment(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        run_random(200);

        // Inverted window: nothing can be visible.
        program_window(300, 200, 100, 100);
        run_random(150);

        // Single point window at the top end of the range, then a zero-height strip.
        program_window(32767, 32767, 32767, 32767);
        send_segment(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        run_random(100);
        program_window(-32768, -50, 32767, -50);
        run_random(100);

        // Back-to-back traffic with an always-ready receiver on a random window.
        sender_idles = 1'b0;
        sink_idles   = 1'b0;
        program_window(-1000 + $urandom_range(500), -800 + $urandom_range(500),
                       $urandom_range(2000), $urandom_range(1500));
        run_random(250);
        sender_idles = 1'b1;
        sink_idles   = 1'b1;

        // A few random windows, small and large.
        repeat (3)
        begin
            int lx, ly;
            lx = $urandom_range(65535) - 32768;
            ly = $urandom_range(65535) - 32768;
            program_window(lx, ly, lx + $urandom_range(3000), ly + $urandom_range(3000));
            run_random(110);
        end

        drain();
        repeat (LATENCY_GUARD) @(posedge clk);
        $display("clipped %0d segments against %0d window settings, %0d of them visible",
                 segments_sent, windows_used, visible_count);
        $display("stalls: random on both sides plus one long receiver hold-off");
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
